// ===== rtl/assert_macros.svh =====
// Assertion macros of the integer parser core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Check a property on every rising edge, skipped while reset is high.
`define AIP_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Check a property on every rising edge, reset included.
`define AIP_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define AIP_ASSERT(label, clk, rst, prop, msg)
`define AIP_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

// ===== rtl/aip_pkg.sv =====
// Types and constants shared by the integer parser files.
package aip_pkg;

  // Widths of the fixed fields
  localparam int CH_W     = 8;
  localparam int VALUE_W  = 64;
  localparam int POS_W    = 16;
  localparam int STATUS_W = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam int SEP_SLOTS  = 4;

  // Positions saturate at the smaller of max length - 1 and the field limit
  localparam int MAX_LEN = 65536;
  localparam logic [POS_W-1:0] POS_CAP =
    ((MAX_LEN - 1) < 65535) ? POS_W'(MAX_LEN - 1) : POS_W'(65535);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ALLOW_MINUS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SEPARATORS   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REQUIRE_FULL = 2'd2;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NO_DIGIT = 2'd1;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd2;
  localparam logic [STATUS_W-1:0] ST_TRAILING = 2'd3;

  // Character codes
  localparam logic [CH_W-1:0] CH_NUL   = 8'h00;
  localparam logic [CH_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CH_W-1:0] CH_0     = 8'h30;
  localparam logic [CH_W-1:0] CH_9     = 8'h39;
  localparam logic [CH_W-1:0] CH_UA    = 8'h41;
  localparam logic [CH_W-1:0] CH_UF    = 8'h46;
  localparam logic [CH_W-1:0] CH_UX    = 8'h58;
  localparam logic [CH_W-1:0] CH_LA    = 8'h61;
  localparam logic [CH_W-1:0] CH_LF    = 8'h66;
  localparam logic [CH_W-1:0] CH_LX    = 8'h78;

  // Parse phase of the current string
  typedef enum logic [2:0] {
    PH_START,
    PH_NUMSTART,
    PH_ZERO,
    PH_PREFIX,
    PH_DIGITS,
    PH_STOPPED,
    PH_DONE
  } phase_t;

  // Classification and multiply-add of one character
  typedef struct packed {
    logic               is_sep;
    logic               is_digit;
    logic               ovf;
    logic [VALUE_W-1:0] acc_next;
  } digit_res_t;

endpackage

// ===== rtl/aip_cfg_if.sv =====
// Configuration write channel of the integer parser.
interface aip_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [aip_pkg::CFG_IDX_W-1:0]    index;
  logic [aip_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/aip_in_if.sv =====
// Character channel of the integer parser.
interface aip_in_if;
  logic                        valid;
  logic                        ready;
  logic [aip_pkg::CH_W-1:0]    ch;
  logic                        last;

  modport source (output valid, ch, last, input ready);
  modport sink   (input valid, ch, last, output ready);
endinterface

// ===== rtl/aip_out_if.sv =====
// Result channel of the integer parser.
interface aip_out_if;
  logic                            valid;
  logic                            ready;
  logic [aip_pkg::STATUS_W-1:0]    status;
  logic [aip_pkg::VALUE_W-1:0]     value;
  logic [aip_pkg::POS_W-1:0]       end_offset;

  modport source (output valid, status, value, end_offset, input ready);
  modport sink   (input valid, status, value, end_offset, output ready);
endinterface

// ===== rtl/aip_digit.sv =====
// Character classifier and radix multiply-add with exact overflow detection.
module aip_digit (
  input  logic [aip_pkg::CH_W-1:0]       ch,
  input  logic                           hex,
  input  logic [aip_pkg::VALUE_W-1:0]    acc,
  input  logic [aip_pkg::CFG_DATA_W-1:0] separators,
  output aip_pkg::digit_res_t            res
);

  localparam int SUM_W = aip_pkg::VALUE_W + 4;

  logic [3:0]       digit;
  logic             is_digit;
  logic             is_sep;
  logic [SUM_W-1:0] acc_wide;
  logic [SUM_W-1:0] sum10;
  logic [SUM_W-1:0] sum16;
  logic [SUM_W-1:0] sum;

  // Match against the separator slots; a zero slot never matches
  always_comb begin
    is_sep = 1'b0;
    for (int i = 0; i < aip_pkg::SEP_SLOTS; i++) begin
      if (separators[i*8 +: 8] != aip_pkg::CH_NUL && separators[i*8 +: 8] == ch) begin
        is_sep = 1'b1;
      end
    end
  end

  // Decode the digit value for the current radix
  always_comb begin
    digit    = 4'd0;
    is_digit = 1'b0;
    if (ch >= aip_pkg::CH_0 && ch <= aip_pkg::CH_9) begin
      digit    = 4'(ch - aip_pkg::CH_0);
      is_digit = 1'b1;
    end else if (hex && ch >= aip_pkg::CH_LA && ch <= aip_pkg::CH_LF) begin
      digit    = 4'(ch - aip_pkg::CH_LA + 8'd10);
      is_digit = 1'b1;
    end else if (hex && ch >= aip_pkg::CH_UA && ch <= aip_pkg::CH_UF) begin
      digit    = 4'(ch - aip_pkg::CH_UA + 8'd10);
      is_digit = 1'b1;
    end
  end

  // Multiply by the radix with shifts, carry the top nibble out for overflow
  assign acc_wide = {4'd0, acc};
  assign sum10    = (acc_wide << 3) + (acc_wide << 1) + {{(SUM_W-4){1'b0}}, digit};
  assign sum16    = {acc, digit};
  assign sum      = hex ? sum16 : sum10;

  assign res.is_sep   = is_sep;
  assign res.is_digit = is_digit;
  assign res.ovf      = |sum[SUM_W-1:aip_pkg::VALUE_W];
  assign res.acc_next = sum[aip_pkg::VALUE_W-1:0];

endmodule

// ===== rtl/ascii_integer_parser_core.sv =====
// Streaming ASCII decimal/hex to 64-bit integer parser, top level.
//
// Characters arrive on the chars channel, one per transfer, with last marking
// the final character of a string. One result per string leaves on the result
// channel: status, value (two's complement when a leading minus was taken)
// and end_offset. Registers are written on the cfg channel, which is always
// ready; write it only while no string is in flight.
// A character passes an input register, then parse logic that updates the
// string state and, on the last character, loads the result register. The
// result register loads when the last character leaves the input register,
// so result valid rises in the cycle after that. Throughput is one character
// per cycle while no last character waits for the result register, set by the
// single multiply-add (shifts and a three-operand 68-bit add) between the
// input register and the state registers.
// While the receiver stalls, characters without last keep flowing; a last
// character waits in the input register until the result register is free.
// Synchronous reset restores allow_minus = 1, no separators, non-strict mode,
// empties both registers and returns the string state to its start.
module ascii_integer_parser_core (
  input  logic             clk,
  input  logic             rst,
  aip_cfg_if.sink          cfg,
  aip_in_if.sink           chars,
  aip_out_if.source        result
);

  // Configuration registers
  logic                           allow_minus;
  logic [aip_pkg::CFG_DATA_W-1:0] separator_chars;
  logic                           require_full_match;

  // Input register
  logic                       s1_valid;
  logic [aip_pkg::CH_W-1:0]   s1_ch;
  logic                       s1_last;
  logic                       s1_fire;

  // String state
  aip_pkg::phase_t            phase, phase_next;
  logic [aip_pkg::VALUE_W-1:0] accumulator, accumulator_next;
  logic                       hex_radix, hex_radix_next;
  logic                       negative_sign, negative_sign_next;
  logic                       digit_seen, digit_seen_next;
  logic                       overflowed, overflowed_next;
  logic [aip_pkg::POS_W-1:0]  char_position, char_position_next;
  logic [aip_pkg::POS_W-1:0]  stop_position, stop_position_next;

  // Result register
  logic                          res_valid;
  logic [aip_pkg::STATUS_W-1:0]  res_status, res_status_next;
  logic [aip_pkg::VALUE_W-1:0]   res_mag, res_mag_next;
  logic                          res_negate, res_negate_next;
  logic [aip_pkg::POS_W-1:0]     res_end, res_end_next;

  // Digit unit inputs and result
  logic                        eff_hex;
  logic [aip_pkg::VALUE_W-1:0] eff_acc;
  aip_pkg::digit_res_t         dig;

  // Take configuration writes at any time
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      allow_minus        <= 1'b1;
      separator_chars    <= '0;
      require_full_match <= 1'b0;
    end else if (cfg.valid) begin
      case (cfg.index)
        aip_pkg::CFG_ALLOW_MINUS:  allow_minus        <= cfg.data[0];
        aip_pkg::CFG_SEPARATORS:   separator_chars    <= cfg.data;
        aip_pkg::CFG_REQUIRE_FULL: require_full_match <= cfg.data[0];
        default: ;
      endcase
    end
  end

  // Advance the input register; a last character needs a free result slot
  assign s1_fire     = s1_valid && (!s1_last || !res_valid || result.ready);
  assign chars.ready = !s1_valid || s1_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (chars.ready) begin
      s1_valid <= chars.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (chars.ready && chars.valid) begin
      s1_ch   <= chars.ch;
      s1_last <= chars.last;
    end
  end

  // The hex prefix switches radix and restarts the accumulator
  assign eff_hex = hex_radix || (phase == aip_pkg::PH_PREFIX);
  assign eff_acc = (phase == aip_pkg::PH_PREFIX) ? '0 : accumulator;

  aip_digit u_digit (
    .ch         (s1_ch),
    .hex        (eff_hex),
    .acc        (eff_acc),
    .separators (separator_chars),
    .res        (dig)
  );

  // Parse one character and build the result on the last one
  always_comb begin
    logic                      do_run;
    logic                      do_start;
    aip_pkg::phase_t           phase_end;
    logic [aip_pkg::POS_W-1:0] stop_end;
    logic [aip_pkg::POS_W-1:0] pos_inc;

    phase_next         = phase;
    accumulator_next   = accumulator;
    hex_radix_next     = hex_radix;
    negative_sign_next = negative_sign;
    digit_seen_next    = digit_seen;
    overflowed_next    = overflowed;
    stop_position_next = stop_position;
    do_run             = 1'b0;
    do_start           = 1'b0;

    if (phase != aip_pkg::PH_STOPPED && phase != aip_pkg::PH_DONE) begin
      if (s1_ch == aip_pkg::CH_NUL) begin
        if (phase == aip_pkg::PH_PREFIX) begin
          phase_next = aip_pkg::PH_STOPPED;
        end else begin
          stop_position_next = char_position;
          phase_next         = aip_pkg::PH_DONE;
        end
      end else begin
        case (phase)
          aip_pkg::PH_START: begin
            if (allow_minus && s1_ch == aip_pkg::CH_MINUS) begin
              negative_sign_next = 1'b1;
              phase_next         = aip_pkg::PH_NUMSTART;
            end else begin
              do_start = 1'b1;
            end
          end
          aip_pkg::PH_NUMSTART: do_start = 1'b1;
          aip_pkg::PH_ZERO: begin
            if (s1_ch == aip_pkg::CH_LX || s1_ch == aip_pkg::CH_UX) begin
              stop_position_next = char_position;
              phase_next         = aip_pkg::PH_PREFIX;
            end else begin
              phase_next = aip_pkg::PH_DIGITS;
              do_run     = 1'b1;
            end
          end
          aip_pkg::PH_PREFIX: begin
            hex_radix_next   = 1'b1;
            accumulator_next = '0;
            digit_seen_next  = 1'b0;
            phase_next       = aip_pkg::PH_DIGITS;
            do_run           = 1'b1;
          end
          default: do_run = 1'b1;
        endcase

        // Leading zero may open a hex prefix
        if (do_start) begin
          if (s1_ch == aip_pkg::CH_0) begin
            accumulator_next = '0;
            digit_seen_next  = 1'b1;
            phase_next       = aip_pkg::PH_ZERO;
          end else begin
            phase_next = aip_pkg::PH_DIGITS;
            do_run     = 1'b1;
          end
        end

        // Skip separators, stop on a non-digit, accumulate otherwise
        if (do_run && !dig.is_sep) begin
          if (!dig.is_digit) begin
            stop_position_next = char_position;
            phase_next         = aip_pkg::PH_STOPPED;
          end else if (dig.ovf) begin
            overflowed_next = 1'b1;
            phase_next      = aip_pkg::PH_DONE;
          end else begin
            accumulator_next = dig.acc_next;
            digit_seen_next  = 1'b1;
          end
        end
      end
    end

    pos_inc = (char_position < aip_pkg::POS_CAP) ? char_position + 1'b1 : char_position;
    char_position_next = pos_inc;

    // Close an open number at the end of the string
    phase_end = phase_next;
    stop_end  = stop_position_next;
    if (phase_next == aip_pkg::PH_PREFIX) begin
      phase_end = aip_pkg::PH_STOPPED;
    end else if (phase_next != aip_pkg::PH_STOPPED && phase_next != aip_pkg::PH_DONE) begin
      stop_end = pos_inc;
    end

    res_negate_next = 1'b0;
    res_mag_next    = '0;
    if (overflowed_next) begin
      res_status_next = aip_pkg::ST_OVERFLOW;
      res_end_next    = '0;
    end else if (!digit_seen_next) begin
      res_status_next = aip_pkg::ST_NO_DIGIT;
      res_end_next    = '0;
    end else if (require_full_match && phase_end == aip_pkg::PH_STOPPED) begin
      res_status_next = aip_pkg::ST_TRAILING;
      res_end_next    = stop_end;
    end else begin
      res_status_next = aip_pkg::ST_OK;
      res_mag_next    = accumulator_next;
      res_negate_next = negative_sign_next;
      res_end_next    = stop_end;
    end

    // Return the string state to its start after the last character
    if (s1_last) begin
      phase_next         = aip_pkg::PH_START;
      accumulator_next   = '0;
      hex_radix_next     = 1'b0;
      negative_sign_next = 1'b0;
      digit_seen_next    = 1'b0;
      overflowed_next    = 1'b0;
      char_position_next = '0;
      stop_position_next = '0;
    end
  end

  // Update the string state on each character transfer out of the input register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= aip_pkg::PH_START;
      accumulator   <= '0;
      hex_radix     <= 1'b0;
      negative_sign <= 1'b0;
      digit_seen    <= 1'b0;
      overflowed    <= 1'b0;
      char_position <= '0;
      stop_position <= '0;
    end else if (s1_fire) begin
      phase         <= phase_next;
      accumulator   <= accumulator_next;
      hex_radix     <= hex_radix_next;
      negative_sign <= negative_sign_next;
      digit_seen    <= digit_seen_next;
      overflowed    <= overflowed_next;
      char_position <= char_position_next;
      stop_position <= stop_position_next;
    end
  end

  // Hold the result until the receiver takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (s1_fire && s1_last) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_last) begin
      res_status <= res_status_next;
      res_mag    <= res_mag_next;
      res_negate <= res_negate_next;
      res_end    <= res_end_next;
    end
  end

  // Negate at the output with two's-complement wrap
  assign result.valid      = res_valid;
  assign result.status     = res_status;
  assign result.value      = res_negate ? ('0 - res_mag) : res_mag;
  assign result.end_offset = res_end;

`include "assert_macros.svh"

  `AIP_ASSERT(a_last_loads_result, clk, rst,
    (s1_fire && s1_last) |=> res_valid,
    "last character did not load a result")
  `AIP_ASSERT(a_state_cleared, clk, rst,
    (s1_fire && s1_last) |=> (phase == aip_pkg::PH_START &&
      char_position == '0 && accumulator == '0),
    "string state not cleared after last character")
  `AIP_ASSERT(a_error_value_zero, clk, rst,
    (res_valid && res_status != aip_pkg::ST_OK) |-> (res_mag == '0),
    "error result carries a nonzero value")
  `AIP_ASSERT(a_error_end_zero, clk, rst,
    (res_valid && (res_status == aip_pkg::ST_OVERFLOW ||
      res_status == aip_pkg::ST_NO_DIGIT)) |-> (res_end == '0),
    "error result carries a nonzero offset")
  `AIP_ASSERT(a_stage_holds, clk, rst,
    (s1_valid && !s1_fire) |=> (s1_valid && $stable(s1_ch) && $stable(s1_last)),
    "waiting character lost")

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench of the streaming ASCII integer parser.
`timescale 1ns / 100ps

module tb;
  import aip_pkg::*;

  localparam int QUIET_LIMIT = 5000;
  localparam int DRAIN_WAIT  = 8;
  localparam int RAND_PHASES = 6;
  localparam int PHASE_ITEMS = 75;

  // Predicts one parse result per string and holds the results still owed
  class parse_tracker;
    typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [VALUE_W-1:0]  value;
      logic [POS_W-1:0]    end_offset;
    } parse_result_t;

    bit                    allow_minus;
    logic [CFG_DATA_W-1:0] separators;
    bit                    full_match;
    phase_t                ph;
    logic [VALUE_W-1:0]    acc;
    bit                    hex_mode;
    bit                    negate;
    bit                    got_digit;
    bit                    too_big;
    logic [POS_W-1:0]      pos;
    logic [POS_W-1:0]      stop_pos;
    parse_result_t         owed_numbers[$];
    int                    errors;

    function new();
      allow_minus = 1'b1;
      separators  = '0;
      full_match  = 1'b0;
      errors      = 0;
      clear_string();
    endfunction

    function void clear_string();
      ph        = PH_START;
      acc       = '0;
      hex_mode  = 1'b0;
      negate    = 1'b0;
      got_digit = 1'b0;
      too_big   = 1'b0;
      pos       = '0;
      stop_pos  = '0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_ALLOW_MINUS:  allow_minus = data[0];
        CFG_SEPARATORS:   separators  = data;
        CFG_REQUIRE_FULL: full_match  = data[0];
        default: ;
      endcase
    endfunction

    // Skip separators, stop on a non-digit, else multiply-add with exact overflow
    function void take_digit(logic [CH_W-1:0] c, logic [POS_W-1:0] at);
      logic [3:0]         d;
      bit                 ok;
      bit                 sep;
      logic [VALUE_W+3:0] wide;
      sep = 1'b0;
      if (c != CH_NUL) begin
        for (int i = 0; i < SEP_SLOTS && i < CFG_DATA_W / CH_W; i++)
          if (separators[i*CH_W +: CH_W] == c) sep = 1'b1;
      end
      if (sep) return;
      ok = 1'b1;
      d  = '0;
      if (c >= CH_0 && c <= CH_9) d = 4'(c - CH_0);
      else if (hex_mode && c >= CH_LA && c <= CH_LF) d = 4'(c - CH_LA + 8'd10);
      else if (hex_mode && c >= CH_UA && c <= CH_UF) d = 4'(c - CH_UA + 8'd10);
      else ok = 1'b0;
      if (!ok) begin
        stop_pos = at;
        ph       = PH_STOPPED;
        return;
      end
      wide = {4'h0, acc} * (VALUE_W+4)'(hex_mode ? 16 : 10) + (VALUE_W+4)'(d);
      if (wide[VALUE_W+3:VALUE_W] != '0) begin
        too_big = 1'b1;
        ph      = PH_DONE;
        return;
      end
      acc       = wide[VALUE_W-1:0];
      got_digit = 1'b1;
    endfunction

    function void start_number(logic [CH_W-1:0] c, logic [POS_W-1:0] at);
      if (c == CH_0) begin
        acc       = '0;
        got_digit = 1'b1;
        ph        = PH_ZERO;
      end else begin
        ph = PH_DIGITS;
        take_digit(c, at);
      end
    endfunction

    // Advance the parse by one transferred character; owe a result on last
    function void note_char(logic [CH_W-1:0] c, bit is_last);
      parse_result_t r;
      if (ph != PH_STOPPED && ph != PH_DONE) begin
        if (c == CH_NUL) begin
          if (ph == PH_PREFIX) ph = PH_STOPPED;
          else begin
            stop_pos = pos;
            ph       = PH_DONE;
          end
        end else begin
          case (ph)
            PH_START: begin
              if (allow_minus && c == CH_MINUS) begin
                negate = 1'b1;
                ph     = PH_NUMSTART;
              end else start_number(c, pos);
            end
            PH_NUMSTART: start_number(c, pos);
            PH_ZERO: begin
              if (c == CH_LX || c == CH_UX) begin
                stop_pos = pos;
                ph       = PH_PREFIX;
              end else begin
                ph = PH_DIGITS;
                take_digit(c, pos);
              end
            end
            PH_PREFIX: begin
              hex_mode  = 1'b1;
              acc       = '0;
              got_digit = 1'b0;
              ph        = PH_DIGITS;
              take_digit(c, pos);
            end
            default: take_digit(c, pos);
          endcase
        end
      end
      if (pos < POS_CAP) pos++;
      if (!is_last) return;

      // Close the string and form its result
      if (ph == PH_PREFIX) ph = PH_STOPPED;
      else if (ph != PH_STOPPED && ph != PH_DONE) stop_pos = pos;
      r = '0;
      if (too_big) r.status = ST_OVERFLOW;
      else if (!got_digit) r.status = ST_NO_DIGIT;
      else if (full_match && ph == PH_STOPPED) begin
        r.status     = ST_TRAILING;
        r.end_offset = stop_pos;
      end else begin
        r.status     = ST_OK;
        r.value      = negate ? -acc : acc;
        r.end_offset = stop_pos;
      end
      owed_numbers.insert(owed_numbers.size(), r);
      clear_string();
    endfunction

    task report(string msg);
      $display("%0t mismatch: %s", $time, msg);
      errors++;
    endtask

    // Compare a transferred result with the oldest owed one
    task check_number(logic [STATUS_W-1:0] status, logic [VALUE_W-1:0] value,
                      logic [POS_W-1:0] end_offset);
      parse_result_t want;
      if (owed_numbers.size() == 0) begin
        report($sformatf("unexpected result status %0d value %0h end %0d",
                         status, value, end_offset));
        return;
      end
      want = owed_numbers.pop_front();
      if (status !== want.status)
        report($sformatf("status %0d, want %0d", status, want.status));
      if (value !== want.value)
        report($sformatf("value %0h, want %0h", value, want.value));
      if (end_offset !== want.end_offset)
        report($sformatf("end_offset %0d, want %0d", end_offset, want.end_offset));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst;

  aip_cfg_if cfg_ch ();
  aip_in_if  char_ch ();
  aip_out_if res_ch ();

  parse_tracker tracker = new();
  logic [CH_W-1:0] text[$];
  int gap_pct   = 0;
  int stall_pct = 0;
  int sent_count = 0;

  ascii_integer_parser_core DUT (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg_ch),
    .chars  (char_ch),
    .result (res_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Stall the result channel at random
  always @(posedge clk) begin
    if (rst) res_ch.ready <= 1'b0;
    else res_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  // Check every result transfer
  always @(posedge clk) begin
    if (!rst && res_ch.valid && res_ch.ready)
      tracker.check_number(res_ch.status, res_ch.value, res_ch.end_offset);
  end

  // End the run when no transfer happens for too long
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (rst || (cfg_ch.valid && cfg_ch.ready) || (char_ch.valid && char_ch.ready) ||
          (res_ch.valid && res_ch.ready)) quiet = 0;
      else quiet++;
    end
    $display("[ascii_integer_parser_core] ERROR");
    $finish;
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    tracker.write_reg(idx, data);
  endtask

  // Write all three registers back to back, then drop valid
  task automatic set_config(bit minus_ok, logic [CFG_DATA_W-1:0] seps, bit strict);
    write_reg(CFG_ALLOW_MINUS, CFG_DATA_W'(minus_ok));
    write_reg(CFG_SEPARATORS, seps);
    write_reg(CFG_REQUIRE_FULL, CFG_DATA_W'(strict));
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic send_char(logic [CH_W-1:0] c, bit is_last);
    while ($urandom_range(99) < gap_pct) begin
      char_ch.valid <= 1'b0;
      @(posedge clk);
    end
    char_ch.valid <= 1'b1;
    char_ch.ch    <= c;
    char_ch.last  <= is_last;
    do @(posedge clk); while (!char_ch.ready);
    tracker.note_char(c, is_last);
    sent_count++;
  endtask

  // Append one character to the string being built
  function automatic void add_char(logic [CH_W-1:0] c);
    text.insert(text.size(), c);
  endfunction

  task automatic send_text();
    for (int i = 0; i < text.size(); i++) send_char(text[i], i == text.size() - 1);
  endtask

  task automatic load_text(string s);
    text.delete();
    for (int i = 0; i < s.len(); i++) add_char(s[i]);
  endtask

  task automatic send_str(string s);
    load_text(s);
    send_text();
  endtask

  // Hold the sender until every owed result has arrived, then let the pipe settle
  task automatic drain();
    char_ch.valid <= 1'b0;
    while (tracker.owed_numbers.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  function automatic logic [CFG_DATA_W-1:0] random_seps();
    logic [CFG_DATA_W-1:0] seps;
    int r;
    seps = '0;
    for (int i = 0; i < CFG_DATA_W / CH_W; i++) begin
      r = $urandom_range(3);
      if (r == 1) seps[i*CH_W +: CH_W] = CH_W'($urandom_range(8'h20, 8'h7E));
      else if (r > 1) seps[i*CH_W +: CH_W] = CH_W'($urandom_range(255));
    end
    return seps;
  endfunction

  task automatic push_sep();
    logic [CH_W-1:0] b;
    b = tracker.separators[$urandom_range(SEP_SLOTS - 1)*CH_W +: CH_W];
    if (b != CH_NUL) add_char(b);
  endtask

  task automatic push_digit(logic [CH_W-1:0] c);
    if ($urandom_range(5) == 0) push_sep();
    add_char(c);
  endtask

  // Build one string: mostly well-formed numbers with random content, some noise
  task automatic build_random_text();
    int              n;
    int              r;
    int              tail;
    bit              hex;
    logic [63:0]     v;
    string           digits;
    logic [CH_W-1:0] c;
    text.delete();
    if ($urandom_range(99) < 12) begin
      n = $urandom_range(1, 5);
      repeat (n) add_char(CH_W'($urandom_range(255)));
      return;
    end
    if ($urandom_range(3) == 0) add_char(CH_MINUS);
    hex = ($urandom_range(2) == 0);
    if (hex) begin
      add_char(CH_0);
      add_char($urandom_range(1) ? CH_LX : CH_UX);
    end
    if ($urandom_range(4) == 0) begin
      // near or past the 64-bit limit
      v = $urandom_range(1) ? ~64'd0 - 64'($urandom_range(2)) : {$urandom, $urandom};
      digits = hex ? $sformatf("%0h", v) : $sformatf("%0d", v);
      if ($urandom_range(1)) digits = {digits, "0"};
      for (int i = 0; i < digits.len(); i++) begin
        c = digits[i];
        if (hex && c >= CH_LA && c <= CH_LF && $urandom_range(1)) c = c - CH_LA + CH_UA;
        push_digit(c);
      end
    end else begin
      n = hex ? $urandom_range(0, 6) : $urandom_range(1, 6);
      repeat (n) begin
        r = $urandom_range(15);
        if (!hex) c = CH_0 + CH_W'($urandom_range(9));
        else if (r < 10) c = CH_0 + CH_W'(r);
        else c = ($urandom_range(1) ? CH_UA : CH_LA) + CH_W'(r - 10);
        push_digit(c);
      end
    end
    tail = $urandom_range(9);
    if (tail == 6 || tail == 7) begin
      repeat ($urandom_range(1, 3)) add_char(CH_W'($urandom_range(255)));
    end else if (tail == 8) begin
      add_char(CH_NUL);
      repeat ($urandom_range(0, 3)) add_char(CH_W'($urandom_range(255)));
    end else if (tail == 9) begin
      repeat ($urandom_range(1, 2)) push_sep();
    end
  endtask

  initial begin
    int start;
    rst           <= 1'b1;
    cfg_ch.valid  <= 1'b0;
    cfg_ch.index  <= '0;
    cfg_ch.data   <= '0;
    char_ch.valid <= 1'b0;
    char_ch.ch    <= '0;
    char_ch.last  <= 1'b0;
    gap_pct   = 26;
    stall_pct = 87;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed strings: sign, bare prefix, prefix without digits, terminator,
    // separator, trailing text, lone terminator, lone zero
    set_config(1'b1, 32'h20272C5F, 1'b0);
    send_str("-5");
    send_str("0x");
    send_str("0Xg");
    load_text("7");
    add_char(CH_NUL);
    add_char(8'hFF);
    send_text();
    send_str("1_2");
    send_str("12a");
    text.delete();
    add_char(CH_NUL);
    send_text();
    send_str("0");
    drain();

    // Random phases, each under its own register setting; the idling mode changes every two phases
    for (int p = 0; p < RAND_PHASES; p++) begin
      gap_pct   = (p < 2) ? 26 : (p < 4) ? 87 : 0;
      stall_pct = (p < 2) ? 87 : (p < 4) ? 26 : 0;
      case (p)
        0: set_config(1'b1, 32'h20272C5F, 1'b0);
        1: begin
          set_config(1'b0, 32'h0, 1'b1);
          // minus in unsigned mode, trailing text in strict mode
          send_str("-1");
          send_str("5z");
        end
        2: set_config(1'b1, 32'hFFFFFFFF, 1'b1);
        3: set_config(1'b0, random_seps(), 1'b0);
        4: set_config(1'b1, 32'h0000005F, 1'b1);
        default: set_config(1'($urandom_range(1)), random_seps(), 1'($urandom_range(1)));
      endcase
      start = sent_count;
      while (sent_count - start < PHASE_ITEMS) begin
        build_random_text();
        send_text();
      end
      drain();
    end

    if (tracker.errors == 0) $display("[ascii_integer_parser_core] OK");
    else $display("[ascii_integer_parser_core] ERROR");
    $finish;
  end

endmodule
